>>> src/dtlv_pkg.sv
// Shared types and constants for the DER TLV header parser.
`default_nettype none
package dtlv_pkg;

	localparam int unsigned TagW = 29;
	localparam int unsigned LenW = 32;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_TAGHI    = 2'd1,
		PH_LENFIRST = 2'd2,
		PH_LENLONG  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [TagW-1:0]   tag;
		logic [2:0]        class_bits;
		logic [2:0]        len_todo;
		logic [2:0]        len_cnt;
		logic [LenW-1:0]   len_acc;
		logic              lead_zero;
		logic [3:0]        hdr_cnt;
		logic [LenW-1:0]   remaining;
	} parse_state_t;

	typedef struct packed {
		logic              status;
		logic              indefinite;
		logic [LenW-1:0]   content_len;
		logic [3:0]        hdr_bytes;
		logic [TagW-1:0]   tag_num;
		logic [2:0]        tag_class_bits;
	} parse_result_t;

endpackage
`default_nettype wire

>>> src/dtlv_step.sv
// Next-state and result logic for one header byte.
`default_nettype none
module dtlv_step #(
	parameter int unsigned TAG_NUMBER_BITS   = 29,
	parameter int unsigned MAX_LENGTH_OCTETS = 4
) (
	input  var dtlv_pkg::parse_state_t  cur,
	input  var logic [7:0]              data_byte,
	input  var logic                    first_byte,
	input  var logic [31:0]             bytes_left,
	input  var logic                    allow_indefinite,
	output dtlv_pkg::parse_state_t      nxt,
	output logic                        emit,
	output dtlv_pkg::parse_result_t     res
);

	localparam logic [35:0] TagLimit = (36'd1 << TAG_NUMBER_BITS) - 36'd1;

	logic        do_fail;
	logic        do_finish;
	logic        do_indef;
	logic [31:0] ok_len;
	logic [35:0] tag_ext;
	logic [31:0] acc_next;
	logic [2:0]  cnt_next;
	logic        lead_now;

	always_comb begin
		nxt       = cur;
		do_fail   = 1'b0;
		do_finish = 1'b0;
		do_indef  = 1'b0;
		ok_len    = '0;
		tag_ext   = {cur.tag, data_byte[6:0]};
		acc_next  = {cur.len_acc[23:0], data_byte};
		cnt_next  = cur.len_cnt + 3'd1;
		lead_now  = (cur.len_cnt == 3'd0) ? (data_byte == 8'h00) : cur.lead_zero;
		if (first_byte) begin
			nxt.class_bits = data_byte[7:5];
			nxt.hdr_cnt    = 4'd1;
			nxt.len_todo   = '0;
			nxt.len_cnt    = '0;
			nxt.len_acc    = '0;
			nxt.lead_zero  = 1'b0;
			if (bytes_left == 32'd0) begin
				nxt.tag       = '0;
				nxt.remaining = '0;
				do_fail       = 1'b1;
			end else begin
				nxt.remaining = bytes_left - 32'd1;
				if (data_byte[4:0] == 5'h1f) begin
					nxt.tag   = '0;
					nxt.phase = dtlv_pkg::PH_TAGHI;
				end else begin
					nxt.tag   = {{(dtlv_pkg::TagW-5){1'b0}}, data_byte[4:0]};
					nxt.phase = dtlv_pkg::PH_LENFIRST;
				end
			end
		end else if (cur.phase != dtlv_pkg::PH_IDLE) begin
			if (cur.remaining == 32'd0) begin
				do_fail = 1'b1;
			end else begin
				nxt.remaining = cur.remaining - 32'd1;
				nxt.hdr_cnt   = cur.hdr_cnt + 4'd1;
				unique case (cur.phase)
					dtlv_pkg::PH_TAGHI: begin
						if (cur.tag == '0 && data_byte == 8'h80) begin
							do_fail = 1'b1;
						end else if (tag_ext > TagLimit) begin
							do_fail = 1'b1;
						end else begin
							nxt.tag = tag_ext[dtlv_pkg::TagW-1:0];
							if (!data_byte[7]) begin
								if (tag_ext < 36'd31) begin
									do_fail = 1'b1;
								end else begin
									nxt.phase = dtlv_pkg::PH_LENFIRST;
								end
							end
						end
					end
					dtlv_pkg::PH_LENFIRST: begin
						if (!data_byte[7]) begin
							ok_len    = {24'd0, data_byte};
							do_finish = 1'b1;
						end else if (data_byte[6:0] == 7'd0 && allow_indefinite &&
								cur.class_bits[0]) begin
							do_indef = 1'b1;
						end else if (data_byte[6:0] == 7'd0 ||
								data_byte[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
							do_fail = 1'b1;
						end else begin
							nxt.len_todo  = data_byte[2:0];
							nxt.len_cnt   = '0;
							nxt.len_acc   = '0;
							nxt.lead_zero = 1'b0;
							nxt.phase     = dtlv_pkg::PH_LENLONG;
						end
					end
					dtlv_pkg::PH_LENLONG: begin
						nxt.len_acc   = acc_next;
						nxt.len_cnt   = cnt_next;
						nxt.lead_zero = lead_now;
						if (cnt_next >= cur.len_todo) begin
							if (acc_next < 32'd128 || lead_now) begin
								do_fail = 1'b1;
							end else begin
								ok_len    = acc_next;
								do_finish = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end

		if (do_finish && ok_len > nxt.remaining) begin
			do_fail   = 1'b1;
			do_finish = 1'b0;
		end

		emit = do_fail || do_finish || do_indef;
		res  = '0;
		if (do_fail) begin
			res.status = 1'b1;
		end else if (do_finish || do_indef) begin
			res.tag_class_bits = nxt.class_bits;
			res.tag_num        = nxt.tag;
			res.hdr_bytes      = nxt.hdr_cnt;
			res.content_len    = do_finish ? ok_len : '0;
			res.indefinite     = do_indef;
		end
		if (emit) begin
			nxt.phase = dtlv_pkg::PH_IDLE;
		end
	end

endmodule
`default_nettype wire

>>> src/der_tlv_header_parser.sv
// Top level of the DER TLV header parser: input stage, parse state and result register.
// The parser takes one element byte per transaction and can accept a byte in every cycle.
// Each byte is captured in an input register, then parsed by short logic against the
// header state, and a header result, when one is due, is written into the result register
// and presented on the output channel from there. The input side stalls
// only when a byte that is ready to be parsed finds the result register still full.
`default_nettype none
module der_tlv_header_parser #(
	parameter int unsigned TAG_NUMBER_BITS   = 29,
	parameter int unsigned MAX_LENGTH_OCTETS = 4
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        cfg_valid,
	output logic            cfg_ready,
	input  var logic        cfg_data,     // allow_indefinite
	input  var logic        s_tvalid,
	output logic            s_tready,
	input  var logic [39:0] s_tdata,      // data_byte, bytes_left
	input  var logic        s_tuser,      // first_byte
	output logic            m_tvalid,
	input  var logic        m_tready,
	output logic [71:0]     m_tdata       // tag_class_bits, tag_num, hdr_bytes,
	                                      // content_len, indefinite, status, zero pad
);

	logic                    allow_indef_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    first_s1;
	logic [31:0]             left_s1;
	logic                    advance;
	dtlv_pkg::parse_state_t  state_q;
	dtlv_pkg::parse_state_t  state_nxt;
	logic                    emit;
	dtlv_pkg::parse_result_t res;
	dtlv_pkg::parse_result_t res_q;
	logic                    m_tvalid_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_indef_q <= 1'b0;
		end else if (cfg_valid) begin
			allow_indef_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			left_s1  <= s_tdata[39:8];
			first_s1 <= s_tuser;
		end
	end

	dtlv_step #(
		.TAG_NUMBER_BITS  (TAG_NUMBER_BITS),
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
	) u_step (
		.cur             (state_q),
		.data_byte       (byte_s1),
		.first_byte      (first_s1),
		.bytes_left      (left_s1),
		.allow_indefinite(allow_indef_q),
		.nxt             (state_nxt),
		.emit            (emit),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.status, res_q.indefinite, res_q.content_len,
		res_q.hdr_bytes, res_q.tag_num, res_q.tag_class_bits};

endmodule
`default_nettype wire
